@@ src/lkr_pkg.sv @@
// ----------------------------------------------------------------------------
// LRU-K replacer package
// Shared widths, request codes and the structs passed between the ring
// cells, the head unit and the control at the top level.
// ----------------------------------------------------------------------------
`default_nettype none

package lkr_pkg;

    localparam int FRAME_TOTAL = 64;
    localparam int IDX_W       = $clog2(FRAME_TOTAL);
    localparam int LEN_W       = IDX_W + 1;
    localparam int CNT_W       = 4;

    localparam logic [CNT_W-1:0] CNT_MAX = 4'd15;

    // request codes
    localparam logic [1:0] REQ_ACCESS = 2'd0;
    localparam logic [1:0] REQ_SET    = 2'd1;
    localparam logic [1:0] REQ_REMOVE = 2'd2;
    localparam logic [1:0] REQ_EVICT  = 2'd3;

    typedef logic [IDX_W-1:0] t_idx;
    typedef logic [LEN_W-1:0] t_len;
    typedef logic [CNT_W-1:0] t_cnt;

    // per-frame state held by one ring cell; cnt of zero means in no list
    typedef struct packed {
        t_cnt cnt;
        logic mark;
        logic in_cache;
        t_idx rank;
    } t_cell;

    typedef struct packed {
        logic [1:0] req_type;
        logic [5:0] frame;
        logic       evictable_flag;
    } t_in_item;

    typedef struct packed {
        logic       victim_valid;
        logic [5:0] victim_frame;
        logic [6:0] evictable_count;
    } t_out_item;

    // control from the sequencer to the head unit
    typedef struct packed {
        logic scan;
        logic apply;
        t_idx pos;
        t_idx frame;
    } t_ctl;

    // what the scan pass gathered
    typedef struct packed {
        t_cell tgt;
        logic  hb_v;
        t_idx  hb_idx;
        t_idx  hb_rank;
        logic  cb_v;
        t_idx  cb_idx;
        t_idx  cb_rank;
    } t_scan;

    // edit applied during the second pass
    typedef struct packed {
        logic  drop_en;
        logic  drop_cache;
        t_idx  drop_rank;
        logic  upd_en;
        t_idx  tgt;
        t_cell val;
    } t_upd;

endpackage

`default_nettype wire

@@ src/lkr_cell.sv @@
// ----------------------------------------------------------------------------
// LRU-K ring cell
// Holds the state of one frame and hands it to its neighbour on each shift.
// ----------------------------------------------------------------------------
`default_nettype none

module lkr_cell (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               i_shift,
    input  lkr_pkg::t_cell    i_d,
    output lkr_pkg::t_cell    o_q
);

    lkr_pkg::t_cell r_q;

    // frame state moves one cell towards the head on each shift
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_q <= '0;
        end else if (i_shift) begin
            r_q <= i_d;
        end
    end

    assign o_q = r_q;

endmodule

`default_nettype wire

@@ src/lkr_head.sv @@
// ----------------------------------------------------------------------------
// LRU-K head unit
// Looks at the cell leaving the ring head: gathers the target frame and the
// oldest evictable frame of each list while scanning, and edits ranks and
// the target entry while applying.
// ----------------------------------------------------------------------------
`default_nettype none

module lkr_head (
    input  wire              i_clk,
    input  lkr_pkg::t_ctl    i_ctl,
    input  lkr_pkg::t_upd    i_upd,
    input  lkr_pkg::t_cell   i_head,
    output lkr_pkg::t_cell   o_feed,
    output lkr_pkg::t_scan   o_scan
);

    lkr_pkg::t_scan r_scan;
    lkr_pkg::t_scan base;
    lkr_pkg::t_scan n_scan;
    logic           used;

    assign used = (i_head.cnt != '0);

    // scan accumulation, restarted at the first position
    always_comb begin
        base = r_scan;
        if (i_ctl.pos == '0) begin
            base.hb_v = 1'b0;
            base.cb_v = 1'b0;
        end
        n_scan = base;
        if (i_ctl.pos == i_ctl.frame) begin
            n_scan.tgt = i_head;
        end
        if (used && i_head.mark && !i_head.in_cache) begin
            if (!base.hb_v || (i_head.rank < base.hb_rank)) begin
                n_scan.hb_v    = 1'b1;
                n_scan.hb_idx  = i_ctl.pos;
                n_scan.hb_rank = i_head.rank;
            end
        end
        if (used && i_head.mark && i_head.in_cache) begin
            if (!base.cb_v || (i_head.rank < base.cb_rank)) begin
                n_scan.cb_v    = 1'b1;
                n_scan.cb_idx  = i_ctl.pos;
                n_scan.cb_rank = i_head.rank;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.scan) begin
            r_scan <= n_scan;
        end
    end

    // edit of the cell fed back to the ring tail
    always_comb begin
        o_feed = i_head;
        if (i_ctl.apply) begin
            if (i_upd.drop_en && used && (i_head.in_cache == i_upd.drop_cache)
                && (i_head.rank > i_upd.drop_rank)) begin
                o_feed.rank = i_head.rank - 1'b1;
            end
            if (i_upd.upd_en && (i_ctl.pos == i_upd.tgt)) begin
                o_feed = i_upd.val;
            end
        end
    end

    assign o_scan = r_scan;

endmodule

`default_nettype wire

@@ src/lru_k_frame_replacer.sv @@
// ----------------------------------------------------------------------------
// LRU-K frame replacer
// Replacement policy over a ring of frame cells with history and cache lists
// kept as per-frame ranks.
//
//  channel  | signals                              | direction
//  ---------+--------------------------------------+----------
//  request  | i_in_valid, o_in_stall, i_in_item    | in
//  result   | o_out_valid, i_out_stall, o_out_item | out
//  config   | i_cfg_we, i_cfg_wdata (k_depth)      | in
//
// Each request takes one ring rotation to scan, a decision state, one
// rotation to apply the edit, then a return to the idle state.
// The ring rotation through the single head unit sets the request time.
// Synchronous active-low reset clears all frames; no clearing pass.
// The result register holds a stalled transfer; the decision state waits
// while it is full and its output is stalled.
// ----------------------------------------------------------------------------
`default_nettype none

module lru_k_frame_replacer (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_in_valid,
    output logic                o_in_stall,
    input  lkr_pkg::t_in_item   i_in_item,
    output logic                o_out_valid,
    input  wire                 i_out_stall,
    output lkr_pkg::t_out_item  o_out_item,
    input  wire                 i_cfg_we,
    input  wire  [3:0]          i_cfg_wdata
);

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_SCAN   = 2'd1;
    localparam logic [1:0] S_DECIDE = 2'd2;
    localparam logic [1:0] S_APPLY  = 2'd3;

    localparam lkr_pkg::t_idx POS_LAST = lkr_pkg::t_idx'(lkr_pkg::FRAME_TOTAL - 1);

    logic [1:0]          r_state, n_state;
    lkr_pkg::t_idx       r_pos, n_pos;
    lkr_pkg::t_in_item   r_req;
    logic [3:0]          r_k;
    lkr_pkg::t_len       r_hlen, r_clen, r_tot;
    lkr_pkg::t_upd       r_upd;
    logic                r_out_v;
    lkr_pkg::t_out_item  r_out;

    lkr_pkg::t_cell      q [lkr_pkg::FRAME_TOTAL];
    lkr_pkg::t_cell      feed;
    lkr_pkg::t_scan      scan;
    lkr_pkg::t_ctl       ctl;
    logic                shift;

    // decision signals
    lkr_pkg::t_upd       d_upd;
    lkr_pkg::t_len       d_hlen, d_clen, d_tot;
    logic                d_vv;
    lkr_pkg::t_idx       d_vf;
    logic [3:0]          k_eff;
    lkr_pkg::t_cnt       c_new;
    logic                inrange, tin;
    logic                out_free, commit, accept;

    assign o_in_stall = (r_state != S_IDLE);
    assign accept     = i_in_valid && !o_in_stall;
    assign out_free   = !r_out_v || !i_out_stall;
    assign commit     = (r_state == S_DECIDE) && out_free;
    assign shift      = (r_state == S_SCAN) || (r_state == S_APPLY);

    assign ctl.scan  = (r_state == S_SCAN);
    assign ctl.apply = (r_state == S_APPLY);
    assign ctl.pos   = r_pos;
    assign ctl.frame = lkr_pkg::t_idx'(r_req.frame);

    // ring of frame cells; the head feeds back into the tail
    for (genvar gi = 0; gi < lkr_pkg::FRAME_TOTAL; gi++) begin : g_ring
        lkr_pkg::t_cell d;
        if (gi == lkr_pkg::FRAME_TOTAL - 1) begin : g_tail
            assign d = feed;
        end else begin : g_mid
            assign d = q[gi + 1];
        end
        lkr_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_shift (shift),
            .i_d     (d),
            .o_q     (q[gi])
        );
    end

    lkr_head u_head (
        .i_clk  (i_clk),
        .i_ctl  (ctl),
        .i_upd  (r_upd),
        .i_head (q[0]),
        .o_feed (feed),
        .o_scan (scan)
    );

    // decision from the scan results
    always_comb begin
        k_eff   = (r_k == 4'd0) ? 4'd1 : r_k;
        inrange = (32'(r_req.frame) < lkr_pkg::FRAME_TOTAL);
        tin     = (scan.tgt.cnt != '0);
        c_new   = (scan.tgt.cnt == lkr_pkg::CNT_MAX) ? lkr_pkg::CNT_MAX
                                                     : scan.tgt.cnt + 1'b1;
        d_upd            = '0;
        d_upd.tgt        = lkr_pkg::t_idx'(r_req.frame);
        d_upd.val        = scan.tgt;
        d_hlen           = r_hlen;
        d_clen           = r_clen;
        d_tot            = r_tot;
        d_vv             = 1'b0;
        d_vf             = '0;
        case (r_req.req_type)
            lkr_pkg::REQ_ACCESS: begin
                if (inrange) begin
                    d_upd.upd_en  = 1'b1;
                    d_upd.val.cnt = c_new;
                    if (c_new >= k_eff) begin
                        d_upd.val.in_cache = 1'b1;
                        if (tin) begin
                            d_upd.drop_en    = 1'b1;
                            d_upd.drop_cache = scan.tgt.in_cache;
                            d_upd.drop_rank  = scan.tgt.rank;
                        end
                        if (tin && scan.tgt.in_cache) begin
                            d_upd.val.rank = lkr_pkg::t_idx'(r_clen - 1'b1);
                        end else begin
                            d_upd.val.rank = lkr_pkg::t_idx'(r_clen);
                            d_clen         = r_clen + 1'b1;
                            if (tin) begin
                                d_hlen = r_hlen - 1'b1;
                            end
                        end
                    end else if (!(tin && !scan.tgt.in_cache)) begin
                        if (tin) begin
                            d_upd.drop_en    = 1'b1;
                            d_upd.drop_cache = 1'b1;
                            d_upd.drop_rank  = scan.tgt.rank;
                            d_clen           = r_clen - 1'b1;
                        end
                        d_upd.val.in_cache = 1'b0;
                        d_upd.val.rank     = lkr_pkg::t_idx'(r_hlen);
                        d_hlen             = r_hlen + 1'b1;
                    end
                end
            end
            lkr_pkg::REQ_SET: begin
                if (inrange && tin) begin
                    d_upd.upd_en   = 1'b1;
                    d_upd.val.mark = r_req.evictable_flag;
                    if (!scan.tgt.mark && r_req.evictable_flag) begin
                        d_tot = r_tot + 1'b1;
                    end
                    if (scan.tgt.mark && !r_req.evictable_flag && (r_tot != '0)) begin
                        d_tot = r_tot - 1'b1;
                    end
                end
            end
            lkr_pkg::REQ_REMOVE: begin
                if (inrange && scan.tgt.mark) begin
                    d_upd.drop_en    = 1'b1;
                    d_upd.drop_cache = scan.tgt.in_cache;
                    d_upd.drop_rank  = scan.tgt.rank;
                    d_upd.upd_en     = 1'b1;
                    d_upd.val.cnt    = '0;
                    d_upd.val.mark   = 1'b0;
                    if (scan.tgt.in_cache) begin
                        d_clen = r_clen - 1'b1;
                    end else begin
                        d_hlen = r_hlen - 1'b1;
                    end
                    if (r_tot != '0) begin
                        d_tot = r_tot - 1'b1;
                    end
                end
            end
            default: begin
                // evict: oldest evictable history frame, else cache frame
                if (scan.hb_v || scan.cb_v) begin
                    d_vv             = 1'b1;
                    d_upd.drop_en    = 1'b1;
                    d_upd.upd_en     = 1'b1;
                    d_upd.val.cnt    = '0;
                    d_upd.val.mark   = 1'b0;
                    if (scan.hb_v) begin
                        d_vf             = scan.hb_idx;
                        d_upd.drop_cache = 1'b0;
                        d_upd.drop_rank  = scan.hb_rank;
                        d_hlen           = r_hlen - 1'b1;
                    end else begin
                        d_vf             = scan.cb_idx;
                        d_upd.drop_cache = 1'b1;
                        d_upd.drop_rank  = scan.cb_rank;
                        d_clen           = r_clen - 1'b1;
                    end
                    d_upd.tgt = d_vf;
                    if (r_tot != '0) begin
                        d_tot = r_tot - 1'b1;
                    end
                end
            end
        endcase
    end

    // sequencer
    always_comb begin
        n_state = r_state;
        n_pos   = r_pos;
        case (r_state)
            S_IDLE: begin
                n_pos = '0;
                if (accept) begin
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                n_pos = (r_pos == POS_LAST) ? '0 : r_pos + 1'b1;
                if (r_pos == POS_LAST) begin
                    n_state = S_DECIDE;
                end
            end
            S_DECIDE: begin
                n_pos = '0;
                if (commit) begin
                    n_state = S_APPLY;
                end
            end
            default: begin
                n_pos = (r_pos == POS_LAST) ? '0 : r_pos + 1'b1;
                if (r_pos == POS_LAST) begin
                    n_state = S_IDLE;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_pos   <= '0;
            r_k     <= 4'd2;
            r_hlen  <= '0;
            r_clen  <= '0;
            r_tot   <= '0;
            r_upd   <= '0;
        end else begin
            r_state <= n_state;
            r_pos   <= n_pos;
            if (i_cfg_we) begin
                r_k <= i_cfg_wdata;
            end
            if (commit) begin
                r_hlen <= d_hlen;
                r_clen <= d_clen;
                r_tot  <= d_tot;
                r_upd  <= d_upd;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_req <= i_in_item;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if (commit) begin
            r_out_v <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_v <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (commit) begin
            r_out.victim_valid    <= d_vv;
            r_out.victim_frame    <= 6'(d_vf);
            r_out.evictable_count <= 7'(d_tot);
        end
    end

    assign o_out_valid = r_out_v;
    assign o_out_item  = r_out;

endmodule

`default_nettype wire
